// ===== hw/rtl/spq_pkg.sv =====
// Shared constants, codes and types for the sorted minimum priority queue.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

  localparam int DEPTH = 16;
  localparam int KEY_W = 32;
  localparam int CAP_W = 5;
  localparam int CNT_W = 5;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int LIM_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic signed [KEY_W-1:0] KEY_NONE = -KEY_W'(1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } st_t;

  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [KEY_W-1:0] new_key;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/spq_cell.sv =====
// One storage cell of the sorted key chain.
`timescale 1ns / 1ps
`default_nettype none
module spq_cell
  import spq_pkg::*;
(
  input  wire logic                    clk,
  input  wire cell_cmd_t               cmd,
  input  wire logic                    valid,
  input  wire logic signed [KEY_W-1:0] left_key,
  input  wire logic                    left_gt,
  input  wire logic signed [KEY_W-1:0] right_key,
  output logic signed [KEY_W-1:0]      key,
  output logic                         gt
);

  logic signed [KEY_W-1:0] key_next;

  assign gt = valid && (key > cmd.new_key);

  always_comb begin
    key_next = key;
    if (cmd.ins) begin
      if (left_gt) begin
        key_next = left_key;
      end else if (gt || !valid) begin
        key_next = cmd.new_key;
      end
    end else if (cmd.rem) begin
      key_next = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_min_priority_queue.sv =====
// Top level of the sorted minimum priority queue.
`timescale 1ns / 1ps
`default_nettype none
// Keeps up to DEPTH signed keys in a row of cells sorted ascending, smallest
// in cell 0. Each input item is an insert, remove-minimum or peek-minimum and
// yields one result item (key, status, count) registered in the cycle after the
// item is accepted. The new key is broadcast to every cell, each cell compares
// it with its own key, and the row shifts right (insert) or left (remove) in
// that same cycle, so one item is taken every cycle; only a stalled result
// that is still held stops the input. Equal keys leave in arrival order.
// The user writes capacity through its own port only while the queue is idle;
// the block does not enforce this. It is limited to DEPTH and resets to 16.
module sorted_min_priority_queue
  import spq_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [1:0]              opcode,
  input  wire logic signed [KEY_W-1:0] key,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [KEY_W-1:0]      result_key,
  output logic [1:0]                   status,
  output logic [CNT_W-1:0]             count,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CAP_W-1:0]        capacity
);

  logic [CAP_W-1:0]        cap;
  logic [OCC_W-1:0]        occ;
  logic [OCC_W-1:0]        occ_next;
  logic                    accept;
  logic                    full;
  logic                    empty;
  logic [LIM_W-1:0]        cap_ext;
  logic [LIM_W-1:0]        limit;
  logic [LIM_W-1:0]        occ_ext;
  cell_cmd_t               cmd;
  logic signed [KEY_W-1:0] res_next;
  st_t                     st_next;
  logic                    out_valid_next;

  logic signed [KEY_W-1:0] cell_key [DEPTH];
  logic                    cell_gt [DEPTH];
  logic                    cell_valid [DEPTH];

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  assign cap_ext = LIM_W'(cap);
  assign limit   = (cap_ext < LIM_W'(DEPTH)) ? cap_ext : LIM_W'(DEPTH);
  assign full    = LIM_W'(occ) >= limit;
  assign empty   = (occ == '0);

  always_comb begin
    cmd.ins     = 1'b0;
    cmd.rem     = 1'b0;
    cmd.new_key = key;
    res_next    = '0;
    st_next     = ST_OK;
    occ_next    = occ;
    unique case (opcode)
      OP_INSERT: begin
        if (full) begin
          st_next = ST_FULL;
        end else begin
          cmd.ins  = accept;
          occ_next = occ + OCC_W'(1);
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          st_next  = ST_EMPTY;
          res_next = KEY_NONE;
        end else begin
          cmd.rem  = accept;
          res_next = cell_key[0];
          occ_next = occ - OCC_W'(1);
        end
      end
      OP_PEEK: begin
        if (empty) begin
          st_next  = ST_EMPTY;
          res_next = KEY_NONE;
        end else begin
          res_next = cell_key[0];
        end
      end
      default: begin
      end
    endcase
  end

  assign occ_ext = LIM_W'(occ_next);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_W-1:0] left_key;
    logic                    left_gt;
    logic signed [KEY_W-1:0] right_key;

    assign cell_valid[i] = (occ > OCC_W'(i));

    if (i == 0) begin : g_first
      assign left_key = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_key = cell_key[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_key = cell_key[i];
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .valid     (cell_valid[i]),
      .left_key  (left_key),
      .left_gt   (left_gt),
      .right_key (right_key),
      .key       (cell_key[i]),
      .gt        (cell_gt[i])
    );
  end

  always_comb begin
    if (accept) begin
      out_valid_next = 1'b1;
    end else if (out_stall) begin
      out_valid_next = out_valid;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= CAP_RESET;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap <= capacity;
      end
      if (accept) begin
        occ <= occ_next;
      end
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_key <= res_next;
      status     <= st_next;
      count      <= occ_ext[CNT_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/spq_checker.sv =====
// Port-level checks for the sorted minimum priority queue, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module spq_checker
  import spq_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic signed [KEY_W-1:0] result_key,
  input wire logic [1:0]              status,
  input wire logic [CNT_W-1:0]        count
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_key) && $stable(count))
    else $error("stalled result item changed");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> (result_key == KEY_NONE) && (count == '0))
    else $error("empty result item has wrong key or count");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> (result_key == '0))
    else $error("full result item has wrong key");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item gave no result item");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item valid after reset");

endmodule

bind sorted_min_priority_queue spq_checker u_spq_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .result_key (result_key),
  .status     (status),
  .count      (count)
);
`default_nettype wire
